>>> rtl/core/slci_pkg.sv
// Shared types, character codes and helper functions of the serial LED command interpreter.
package slci_pkg;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_ONE   = 8'h31;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_E     = 8'h45;
  localparam logic [7:0] CHAR_R     = 8'h52;
  localparam logic [7:0] CHAR_N     = 8'h4E;
  localparam logic [7:0] CHAR_F     = 8'h46;
  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_Q     = 8'h51;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
  localparam logic [7:0] CASE_SHIFT = 8'h20;

  localparam logic [15:0] LED_PIN_MASK = 16'h2727;
  localparam logic [7:0]  LED_ALL_ON   = 8'hFF;
  localparam logic [7:0]  LED_ALL_OFF  = 8'h00;
  localparam logic [8:0]  PARSE_SAT    = 9'd256;
  localparam logic [8:0]  PARSE_MAX    = 9'd255;

  // Pin driven by each LED bit, bit 0 first.
  localparam logic [3:0] PIN_OF_BIT [8] = '{4'd0, 4'd1, 4'd2, 4'd5, 4'd13, 4'd8, 4'd9, 4'd10};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BODY,
    ST_CR,
    ST_LF
  } ctrl_state_t;

  typedef enum logic [1:0] {
    REPLY_NONE,
    REPLY_ECHO,
    REPLY_ERR,
    REPLY_QUERY
  } reply_kind_t;

  typedef struct packed {
    logic store;
    logic line_end;
    logic overflow;
    logic emit_body;
    logic emit_cr;
    logic emit_lf;
  } slci_cmd_t;

  typedef struct packed {
    logic        eol;
    logic        line_full;
    reply_kind_t line_reply;
    logic        body_done;
    logic        out_free;
  } slci_status_t;

  function automatic logic [15:0] spread_leds(input logic [7:0] v);
    logic [15:0] pins;
    pins = '0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) begin
        pins[PIN_OF_BIT[i]] = 1'b1;
      end
    end
    return pins & LED_PIN_MASK;
  endfunction

  function automatic logic [7:0] err_char(input logic [1:0] pos);
    logic [7:0] ch;
    case (pos)
      2'd0:    ch = CHAR_E;
      default: ch = CHAR_R;
    endcase
    return ch;
  endfunction

endpackage

>>> rtl/core/serial_led_command_interpreter.sv
// Top level of the serial LED command interpreter: controller, datapath and checks.
// A stored byte goes into the line store; a line end with a reply starts the body state.
// Reply characters leave one per cycle while out_ready allows; a reply of N characters
// (up to LINE_CAPACITY+1) holds the input until it ends. The rate is set by the single
// output register and the one-read-port line store feeding it.
// Reset (rst_n, synchronous, active low): line empty, LED register off, no reply pending.
module serial_led_command_interpreter #(
  parameter int LINE_CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_tx_byte,
  output logic        out_last_of_reply,
  output logic [15:0] out_led_pins
);

  // Command and status bundles between the controller and the datapath.
  slci_pkg::slci_cmd_t    cmd;
  slci_pkg::slci_status_t status;

  // Controller: take a transaction only when idle, then walk body, CR and LF.
  slci_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: hold the line, analyse it as it arrives, drive the reply register.
  slci_datapath #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .rx_byte       (in_rx_byte),
    .cmd           (cmd),
    .status        (status),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .tx_byte       (out_tx_byte),
    .last_of_reply (out_last_of_reply),
    .led_pins      (out_led_pins)
  );

  // Only the wired LED pins may ever be driven.
  a_led_mask : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_led_pins & ~slci_pkg::LED_PIN_MASK) == 16'h0000))
    else $error("LED pin image drives an unused pin");

  // While a reply is still mid-way, no new input transaction may be taken.
  a_no_input_mid_reply : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_of_reply) |-> !in_ready)
    else $error("input accepted before reply finished");

  // A reply character that is not the last is always followed by another one.
  a_reply_continues : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_of_reply) |=> out_valid)
    else $error("reply stopped before its final character");

endmodule

>>> rtl/core/slci_ctrl.sv
// Controller state machine: input acceptance and reply sequencing.
module slci_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  slci_pkg::slci_status_t status,
  output slci_pkg::slci_cmd_t    cmd
);

  slci_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slci_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      slci_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (status.eol) begin
            cmd.line_end = 1'b1;
            if (status.line_reply != slci_pkg::REPLY_NONE) begin
              state_nxt = slci_pkg::ST_BODY;
            end
          end else if (status.line_full) begin
            cmd.overflow = 1'b1;
            state_nxt    = slci_pkg::ST_BODY;
          end else begin
            cmd.store = 1'b1;
          end
        end
      end
      slci_pkg::ST_BODY: begin
        if (status.out_free) begin
          cmd.emit_body = 1'b1;
          if (status.body_done) begin
            state_nxt = slci_pkg::ST_CR;
          end
        end
      end
      slci_pkg::ST_CR: begin
        if (status.out_free) begin
          cmd.emit_cr = 1'b1;
          state_nxt   = slci_pkg::ST_LF;
        end
      end
      slci_pkg::ST_LF: begin
        if (status.out_free) begin
          cmd.emit_lf = 1'b1;
          state_nxt   = slci_pkg::ST_IDLE;
        end
      end
      default: state_nxt = slci_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> rtl/core/slci_datapath.sv
// Datapath: line store, running line analysis, LED register and output register.
module slci_datapath #(
  parameter int LINE_CAPACITY = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [7:0]             rx_byte,
  input  slci_pkg::slci_cmd_t    cmd,
  output slci_pkg::slci_status_t status,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [7:0]             tx_byte,
  output logic                   last_of_reply,
  output logic [15:0]            led_pins
);

  localparam int AW = $clog2(LINE_CAPACITY);
  localparam int IW = (AW > 3) ? AW : 3;
  localparam logic [AW-1:0] FULL_LEN = AW'(LINE_CAPACITY - 1);

  logic [7:0] line_mem [LINE_CAPACITY];
  logic [7:0] rd_data_r;

  logic [AW-1:0] line_len_r, line_len_nxt;
  logic [AW-1:0] eff_len_r, eff_len_nxt;
  logic          nul_seen_r, nul_seen_nxt;
  logic [7:0]    cmd_char_r, cmd_char_nxt;
  logic [8:0]    pval_r, pval_nxt;
  logic          pok_r, pok_nxt;
  logic [7:0]    led_r, led_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] blast_r, blast_nxt;
  slci_pkg::reply_kind_t kind_r, kind_nxt;

  logic        out_valid_r;
  logic [7:0]  tx_byte_r;
  logic        last_r;
  logic [15:0] led_pins_r;

  logic              is_digit;
  logic [12:0]       pval_mul;
  logic [7:0]        cmd_upper;
  slci_pkg::reply_kind_t line_reply;
  logic [7:0]        led_line;
  logic [AW-1:0]     rd_addr;
  logic [7:0]        body_char;
  logic [2:0]        q_bit;

  assign is_digit = (rx_byte >= slci_pkg::CHAR_ZERO) && (rx_byte <= slci_pkg::CHAR_NINE);
  assign pval_mul = {1'b0, pval_r, 3'b000} + {3'b000, pval_r, 1'b0}
                  + {5'b0, rx_byte - slci_pkg::CHAR_ZERO};

  // Command decision for the line held so far.
  always_comb begin
    cmd_upper = cmd_char_r;
    if (cmd_char_r >= slci_pkg::CHAR_LO_A && cmd_char_r <= slci_pkg::CHAR_LO_Z) begin
      cmd_upper = cmd_char_r - slci_pkg::CASE_SHIFT;
    end
    led_line   = led_r;
    line_reply = slci_pkg::REPLY_ERR;
    if (eff_len_r == '0) begin
      line_reply = slci_pkg::REPLY_NONE;
    end else begin
      unique case (cmd_upper)
        slci_pkg::CHAR_E: line_reply = slci_pkg::REPLY_ECHO;
        slci_pkg::CHAR_N: begin
          line_reply = slci_pkg::REPLY_ECHO;
          led_line   = slci_pkg::LED_ALL_ON;
        end
        slci_pkg::CHAR_F: begin
          line_reply = slci_pkg::REPLY_ECHO;
          led_line   = slci_pkg::LED_ALL_OFF;
        end
        slci_pkg::CHAR_P: begin
          if (pok_r && eff_len_r > AW'(1) && pval_r <= slci_pkg::PARSE_MAX) begin
            line_reply = slci_pkg::REPLY_ECHO;
            led_line   = pval_r[7:0];
          end
        end
        slci_pkg::CHAR_Q: line_reply = slci_pkg::REPLY_QUERY;
        default:          line_reply = slci_pkg::REPLY_ERR;
      endcase
    end
  end

  always_comb begin
    status.eol        = (rx_byte == slci_pkg::CHAR_CR) || (rx_byte == slci_pkg::CHAR_LF);
    status.line_full  = (line_len_r == FULL_LEN);
    status.line_reply = line_reply;
    status.body_done  = (idx_r == blast_r);
    status.out_free   = !out_valid_r || out_ready;
  end

  // Line tracking and reply set-up.
  always_comb begin
    line_len_nxt = line_len_r;
    eff_len_nxt  = eff_len_r;
    nul_seen_nxt = nul_seen_r;
    cmd_char_nxt = cmd_char_r;
    pval_nxt     = pval_r;
    pok_nxt      = pok_r;
    led_nxt      = led_r;
    kind_nxt     = kind_r;
    blast_nxt    = blast_r;
    idx_nxt      = idx_r;
    if (cmd.store) begin
      line_len_nxt = line_len_r + AW'(1);
      if (line_len_r == '0) begin
        cmd_char_nxt = rx_byte;
      end
      if (!nul_seen_r) begin
        if (rx_byte == slci_pkg::CHAR_NUL) begin
          nul_seen_nxt = 1'b1;
        end else begin
          eff_len_nxt = eff_len_r + AW'(1);
          if (line_len_r != '0 && pok_r) begin
            if (!is_digit) begin
              pok_nxt = 1'b0;
            end else if (pval_mul > 13'(slci_pkg::PARSE_SAT)) begin
              pval_nxt = slci_pkg::PARSE_SAT;
            end else begin
              pval_nxt = pval_mul[8:0];
            end
          end
        end
      end
    end
    if (cmd.line_end || cmd.overflow) begin
      line_len_nxt = '0;
      eff_len_nxt  = '0;
      nul_seen_nxt = 1'b0;
      pval_nxt     = '0;
      pok_nxt      = 1'b1;
      idx_nxt      = '0;
    end
    if (cmd.line_end) begin
      led_nxt  = led_line;
      kind_nxt = line_reply;
      unique case (line_reply)
        slci_pkg::REPLY_ECHO:  blast_nxt = IW'(eff_len_r - AW'(1));
        slci_pkg::REPLY_QUERY: blast_nxt = IW'(7);
        default:               blast_nxt = IW'(2);
      endcase
    end
    if (cmd.overflow) begin
      kind_nxt  = slci_pkg::REPLY_ERR;
      blast_nxt = IW'(2);
    end
    if (cmd.emit_body) begin
      idx_nxt = status.body_done ? '0 : idx_r + IW'(1);
    end
  end

  // Prefetch the next echo character so one leaves per cycle while the output register is free.
  assign rd_addr = (cmd.emit_body && !status.body_done) ? AW'(idx_r + IW'(1)) : idx_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      line_mem[line_len_r] <= rx_byte;
    end
    rd_data_r <= line_mem[rd_addr];
  end

  assign q_bit = 3'd7 - idx_r[2:0];

  always_comb begin
    unique case (kind_r)
      slci_pkg::REPLY_ECHO:  body_char = rd_data_r;
      slci_pkg::REPLY_QUERY: body_char = led_r[q_bit] ? slci_pkg::CHAR_ONE : slci_pkg::CHAR_ZERO;
      default:               body_char = slci_pkg::err_char(idx_r[1:0]);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_len_r  <= '0;
      eff_len_r   <= '0;
      nul_seen_r  <= 1'b0;
      cmd_char_r  <= slci_pkg::CHAR_NUL;
      pval_r      <= '0;
      pok_r       <= 1'b1;
      led_r       <= slci_pkg::LED_ALL_OFF;
      kind_r      <= slci_pkg::REPLY_NONE;
      blast_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      line_len_r <= line_len_nxt;
      eff_len_r  <= eff_len_nxt;
      nul_seen_r <= nul_seen_nxt;
      cmd_char_r <= cmd_char_nxt;
      pval_r     <= pval_nxt;
      pok_r      <= pok_nxt;
      led_r      <= led_nxt;
      kind_r     <= kind_nxt;
      blast_r    <= blast_nxt;
      idx_r      <= idx_nxt;
      if (cmd.emit_body || cmd.emit_cr || cmd.emit_lf) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_body || cmd.emit_cr || cmd.emit_lf) begin
      last_r     <= cmd.emit_lf;
      led_pins_r <= slci_pkg::spread_leds(led_r);
      if (cmd.emit_body) begin
        tx_byte_r <= body_char;
      end else if (cmd.emit_cr) begin
        tx_byte_r <= slci_pkg::CHAR_CR;
      end else begin
        tx_byte_r <= slci_pkg::CHAR_LF;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign tx_byte       = tx_byte_r;
  assign last_of_reply = last_r;
  assign led_pins      = led_pins_r;

endmodule
